/* rtl/dms_pkg.sv */
// Shared widths, constants and handshake structures for the division magic-number search.
package dms_pkg;

  localparam int unsigned NumW  = 8;
  localparam int unsigned MulW  = 9;
  localparam int unsigned ShW   = 5;
  localparam int unsigned MagW  = 17;
  localparam int unsigned AccW  = NumW + MagW;
  localparam int unsigned IdxW  = 5;

  localparam logic [ShW-1:0]  FirstShift = ShW'(8);
  localparam logic [ShW-1:0]  LastShift  = ShW'(16);
  localparam logic [NumW-1:0] NumMax     = 8'hFF;

  typedef struct packed {
    logic            start;
    logic [ShW-1:0]  shift;
    logic [NumW-1:0] divisor;
  } dms_req_t;

  typedef struct packed {
    logic            done;
    logic [MagW-1:0] mul;
  } dms_rsp_t;

endpackage

/* rtl/div8_magic_search.sv */
// Top level: searches the multiply-and-shift pair for unsigned 8-bit division by a divisor.
//
//  channel  direction  handshake                  payload
//  in       input      in_valid_i / in_ready_o    divisor_value_i[7:0]
//  out      output     out_valid_o / out_ready_i  magic_multiplier_o[8:0], shift_amount_o[4:0]
//
// A zero divisor or a power of two goes from idle straight to the done state, whose result
// enters the output register once that is free. Any other divisor runs, for each shift
// tried from 8 up to 16, the serial reciprocal divider and then tests up to 256
// numerators, one per cycle, before its result goes to the done state. One item is
// worked on at a time.
// After reset the block is idle with no result pending.
// A finished result waits in the output register, and the next item is taken meanwhile.
module div8_magic_search (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [dms_pkg::NumW-1:0]  divisor_value_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [dms_pkg::MulW-1:0]  magic_multiplier_o,
  output logic [dms_pkg::ShW-1:0]   shift_amount_o
);
  import dms_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StDiv,
    StTest,
    StDone
  } state_e;

  state_e          state_q, state_d;
  logic            ovalid_q, ovalid_d;
  logic [MulW-1:0] omul_q, omul_d;
  logic [ShW-1:0]  osh_q, osh_d;
  logic [MulW-1:0] rmul_q, rmul_d;
  logic [ShW-1:0]  rsh_q, rsh_d;
  logic [NumW-1:0] d_q, d_d;
  logic [ShW-1:0]  s_q, s_d;
  logic [MagW-1:0] mul_q, mul_d;
  logic [AccW-1:0] acc_q, acc_d;
  logic [NumW-1:0] n_q, n_d;
  logic [NumW-1:0] qn_q, qn_d;
  logic [NumW-1:0] rn_q, rn_d;

  dms_req_t        req;
  dms_rsp_t        rsp;
  logic            accept;
  logic            pow2;
  logic [ShW-1:0]  log2_d;
  logic [NumW-1:0] got;
  logic [NumW-1:0] rn_inc;

  always_comb begin
    log2_d = '0;
    for (int i = 0; i < NumW; i++) begin
      if (divisor_value_i[i]) begin
        log2_d = ShW'(i);
      end
    end
  end

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign pow2       = ((divisor_value_i & (divisor_value_i - NumW'(1))) == '0);
  assign got        = NumW'(acc_q >> s_q);
  assign rn_inc     = rn_q + NumW'(1);

  always_comb begin
    state_d  = state_q;
    ovalid_d = ovalid_q;
    omul_d   = omul_q;
    osh_d    = osh_q;
    rmul_d   = rmul_q;
    rsh_d    = rsh_q;
    d_d      = d_q;
    s_d      = s_q;
    mul_d    = mul_q;
    acc_d    = acc_q;
    n_d      = n_q;
    qn_d     = qn_q;
    rn_d     = rn_q;
    req      = '{start: 1'b0, shift: s_q, divisor: d_q};

    if (out_ready_i) begin
      ovalid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (accept) begin
          d_d = divisor_value_i;
          if (divisor_value_i == '0) begin
            rmul_d  = '0;
            rsh_d   = '0;
            state_d = StDone;
          end else if (pow2) begin
            rmul_d  = MulW'(1);
            rsh_d   = log2_d;
            state_d = StDone;
          end else begin
            s_d       = FirstShift;
            req.start = 1'b1;
            req.shift = FirstShift;
            req.divisor = divisor_value_i;
            state_d   = StDiv;
          end
        end
      end
      StDiv: begin
        if (rsp.done) begin
          mul_d   = rsp.mul;
          acc_d   = '0;
          n_d     = '0;
          qn_d    = '0;
          rn_d    = '0;
          state_d = StTest;
        end
      end
      StTest: begin
        if (got != qn_q) begin
          if (s_q == LastShift) begin
            rmul_d  = MulW'(mul_q);
            rsh_d   = s_q;
            state_d = StDone;
          end else begin
            s_d       = s_q + ShW'(1);
            req.start = 1'b1;
            req.shift = s_q + ShW'(1);
            state_d   = StDiv;
          end
        end else if (n_q == NumMax) begin
          rmul_d  = MulW'(mul_q);
          rsh_d   = s_q;
          state_d = StDone;
        end else begin
          n_d   = n_q + NumW'(1);
          acc_d = acc_q + AccW'(mul_q);
          if (rn_inc == d_q) begin
            rn_d = '0;
            qn_d = qn_q + NumW'(1);
          end else begin
            rn_d = rn_inc;
          end
        end
      end
      StDone: begin
        if (!ovalid_q || out_ready_i) begin
          ovalid_d = 1'b1;
          omul_d   = rmul_q;
          osh_d    = rsh_q;
          state_d  = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  dms_recip u_recip (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    omul_q <= omul_d;
    osh_q  <= osh_d;
    rmul_q <= rmul_d;
    rsh_q  <= rsh_d;
    d_q    <= d_d;
    s_q    <= s_d;
    mul_q  <= mul_d;
    acc_q  <= acc_d;
    n_q    <= n_d;
    qn_q   <= qn_d;
    rn_q   <= rn_d;
  end

  assign out_valid_o        = ovalid_q;
  assign magic_multiplier_o = omul_q;
  assign shift_amount_o     = osh_q;

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.done |-> state_q == StDiv)
    else $error("reciprocal result outside the division phase");

  a_shift_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StTest || state_q == StDiv) |-> (s_q >= FirstShift && s_q <= LastShift))
    else $error("search shift out of range");

  a_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StTest |-> rn_q < d_q)
    else $error("numerator remainder not below divisor");

  a_shift_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> shift_amount_o <= LastShift)
    else $error("result shift above its bound");

endmodule

/* rtl/dms_recip.sv */
// Bit-serial restoring divider that forms ceil(2^shift / divisor), one quotient bit per cycle.
module dms_recip (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dms_pkg::dms_req_t req_i,
  output dms_pkg::dms_rsp_t rsp_o
);
  import dms_pkg::*;

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [ShW-1:0]  sh_q, sh_d;
  logic [NumW-1:0] div_q, div_d;
  logic [NumW-1:0] rem_q, rem_d;
  logic [MagW-1:0] quo_q, quo_d;
  logic [MagW-1:0] mul_q, mul_d;

  logic            bit_in;
  logic [NumW:0]   rem_shl;
  logic            take;
  logic [NumW-1:0] rem_nx;
  logic [MagW-1:0] quo_nx;

  always_comb begin
    bit_in  = (idx_q == IdxW'(sh_q));
    rem_shl = {rem_q, bit_in};
    take    = (rem_shl >= {1'b0, div_q});
    rem_nx  = take ? NumW'(rem_shl - {1'b0, div_q}) : NumW'(rem_shl);
    quo_nx  = {quo_q[MagW-2:0], take};

    busy_d = busy_q;
    done_d = 1'b0;
    idx_d  = idx_q;
    sh_d   = sh_q;
    div_d  = div_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    mul_d  = mul_q;

    if (req_i.start) begin
      busy_d = 1'b1;
      idx_d  = IdxW'(MagW - 1);
      sh_d   = req_i.shift;
      div_d  = req_i.divisor;
      rem_d  = '0;
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = rem_nx;
      quo_d = quo_nx;
      idx_d = idx_q - IdxW'(1);
      if (idx_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        mul_d  = quo_nx + MagW'(rem_nx != '0);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    sh_q  <= sh_d;
    div_q <= div_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    mul_q <= mul_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.mul  = mul_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("divider started while busy");

  a_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> rem_q < div_q)
    else $error("partial remainder not below divisor");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("done without a running division");

endmodule
